@@ sv/csfu_pkg.sv @@
// shared types, register codes and helpers of the csi frame unpacker
package csfu_pkg;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_MODE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_START = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_START  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_END    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT      = 3'd5;

  // register widths and reset values
  localparam int FS_W  = 24;
  localparam int LS_W  = 16;
  localparam int DIM_W = 13;
  localparam logic [DIM_W-1:0] WIDTH_RST  = 13'd1280;
  localparam logic [DIM_W-1:0] HEIGHT_RST = 13'd720;

  // pixel modes
  localparam logic MODE_DEPTH = 1'b0;
  localparam logic MODE_YUYV  = 1'b1;

  // byte position inside a pixel group
  localparam logic [1:0] PH_Y0 = 2'd0;
  localparam logic [1:0] PH_U  = 2'd1;
  localparam logic [1:0] PH_Y1 = 2'd2;
  localparam logic [1:0] PH_V  = 2'd3;

  // neutral chroma used when a line ends after y0 and u
  localparam logic [7:0] CHROMA_ZERO = 8'd128;

  // queue between parser and converter
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef enum logic [2:0] {
    RG_IDLE       = 3'd0,
    RG_FRAME_LEAD = 3'd1,
    RG_LINE_LEAD  = 3'd2,
    RG_ACTIVE     = 3'd3,
    RG_LINE_TAIL  = 3'd4,
    RG_DONE       = 3'd5
  } region_t;

  typedef enum logic [1:0] {
    JOB_DEPTH   = 2'd0,
    JOB_RGB_ONE = 2'd1,
    JOB_RGB_TWO = 2'd2
  } job_kind_t;

  // one pixel job: depth uses b0/b1, yuyv uses y0=b0 u=b1 y1=b2 v=b3
  typedef struct packed {
    job_kind_t  kind;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] b3;
    logic       eol;
    logic       eof;
  } job_t;

  // floor shift by 8 and clamp to one byte
  function automatic logic [7:0] clamp8(input logic signed [19:0] t);
    if (t < 20'sd0) begin
      clamp8 = 8'd0;
    end else if (t[19:16] != 4'd0) begin
      clamp8 = 8'hFF;
    end else begin
      clamp8 = t[15:8];
    end
  endfunction

endpackage

@@ sv/csi_frame_unpack_yuyv_z16_core.sv @@
// top level of the csi frame unpacker: byte parser, job queue and pixel converter
//
// Takes one frame-buffer byte per clock and turns it into 16-bit depth pixels
// (little-endian byte pairs) or BT.601 RGB pixels (each Y0 U Y1 V group gives two
// pixels). A byte flagged in in_tuser restarts the frame; frame lead, line lead
// and line tail bytes are skipped and bytes after the last line are dropped
// until the next frame start. The parser updates its region counters for each byte
// it takes, so a byte is taken every clock while the four-entry job queue has room.
// A result passes the queue, the product register and the output register after the
// byte that completes it; the output register hands over one result per clock while
// out_ready is high, so a YUYV group gives it two results against four input bytes.
// Configuration is written by the user only while no frame data is in flight; the
// block does not enforce this. No clearing pass is needed after reset.
module csi_frame_unpack_yuyv_z16_core import csfu_pkg::*; #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // byte input
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // [7:0] data_byte
  input  logic                  in_tuser,   // [0] frame_first
  // pixel output
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [39:0]           out_tdata,  // [7:0] red, [15:8] green, [23:16] blue,
                                            // [39:24] depth
  output logic                  out_tlast,  // end_of_line
  output logic [1:0]            out_tuser,  // [0] end_of_frame, [1] last_of_burst
  // register writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic        push_valid, push_ready;
  job_t        push_job;
  logic        pop_valid, pop_ready;
  job_t        pop_job;
  logic [7:0]  red, green, blue;
  logic [15:0] depth;
  logic        eol, eof, last;

  assign cfg_ready = 1'b1;

  // byte parser
  csfu_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_byte    (in_tdata),
    .in_first   (in_tuser),
    .cfg_wr     (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job)
  );

  // job queue
  csfu_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_job    (pop_job)
  );

  // pixel converter
  csfu_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (pop_valid),
    .job_ready (pop_ready),
    .job       (pop_job),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_red   (red),
    .out_green (green),
    .out_blue  (blue),
    .out_depth (depth),
    .out_eol   (eol),
    .out_eof   (eof),
    .out_last  (last)
  );

  // output packing
  assign out_tdata = {depth, blue, green, red};
  assign out_tlast = eol;
  assign out_tuser = {last, eof};

endmodule

@@ sv/csfu_queue.sv @@
// small job queue between the byte parser and the pixel converter
module csfu_queue import csfu_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  output logic push_ready,
  input  job_t push_job,
  output logic pop_valid,
  input  logic pop_ready,
  output job_t pop_job
);

  job_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QPTR_W:0]   fill_r;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (fill_r != (QPTR_W+1)'(QUEUE_DEPTH));
  assign pop_valid  = (fill_r != '0);
  assign pop_job    = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill_r <= fill_r + 1'b1;
      end else if (!do_push && do_pop) begin
        fill_r <= fill_r - 1'b1;
      end
    end
  end

endmodule

@@ sv/csfu_front.sv @@
// byte parser: configuration registers, frame region tracking and pixel job builder
module csfu_front import csfu_pkg::*; #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            in_byte,
  input  logic                  in_first,
  input  logic                  cfg_wr,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  push_valid,
  input  logic                  push_ready,
  output job_t                  push_job
);

  localparam int EW = $clog2(MAX_WIDTH + 1);
  localparam int EH = $clog2(MAX_HEIGHT + 1);
  localparam int LW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int CW = EH + 1;

  // configuration registers
  logic             mode_r;
  logic [FS_W-1:0]  fs_r;
  logic [LS_W-1:0]  ls_r;
  logic [LS_W-1:0]  le_r;
  logic [DIM_W-1:0] width_r;
  logic [DIM_W-1:0] height_r;

  // parser state
  region_t          region_r, region_nxt;
  logic [FS_W-1:0]  cnt_r, cnt_nxt;
  logic [LW-1:0]    line_r, line_nxt;
  logic [1:0]       phase_r, phase_nxt;
  logic [7:0]       h0_r, h0_nxt;
  logic [7:0]       h1_r, h1_nxt;
  logic [7:0]       h2_r, h2_nxt;

  logic             accept;
  logic [EW-1:0]    eff_w;
  logic [EH-1:0]    eff_h;
  logic             fs_zero, ls_zero, le_zero;
  region_t          lead_or_active;
  region_t          base_rgn;
  logic [FS_W-1:0]  base_cnt;
  logic [LW-1:0]    base_line;
  logic [1:0]       base_phase;
  logic [FS_W-1:0]  cnt_inc;
  logic [FS_W-1:0]  rgn_len;
  logic             rgn_end;
  logic             last_ln;

  assign in_ready = push_ready;
  assign accept   = in_valid && push_ready;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_DEPTH;
      fs_r     <= '0;
      ls_r     <= '0;
      le_r     <= '0;
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
    end else if (cfg_wr) begin
      case (cfg_index)
        CFG_PIXEL_MODE:  mode_r   <= cfg_data[0];
        CFG_FRAME_START: fs_r     <= cfg_data[FS_W-1:0];
        CFG_LINE_START:  ls_r     <= cfg_data[LS_W-1:0];
        CFG_LINE_END:    le_r     <= cfg_data[LS_W-1:0];
        CFG_WIDTH:       width_r  <= cfg_data[DIM_W-1:0];
        CFG_HEIGHT:      height_r <= cfg_data[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // effective dimensions, zero taken as one and large values saturated
  always_comb begin
    if (width_r == '0) begin
      eff_w = EW'(1);
    end else if ({1'b0, width_r} > (DIM_W+1)'(MAX_WIDTH)) begin
      eff_w = EW'(MAX_WIDTH);
    end else begin
      eff_w = EW'(width_r);
    end
    if (height_r == '0) begin
      eff_h = EH'(1);
    end else if ({1'b0, height_r} > (DIM_W+1)'(MAX_HEIGHT)) begin
      eff_h = EH'(MAX_HEIGHT);
    end else begin
      eff_h = EH'(height_r);
    end
  end

  assign fs_zero        = (fs_r == '0);
  assign ls_zero        = (ls_r == '0);
  assign le_zero        = (le_r == '0);
  assign lead_or_active = ls_zero ? RG_ACTIVE : RG_LINE_LEAD;

  // frame start restarts from the frame lead, skipping empty leads
  always_comb begin
    if (in_first) begin
      base_rgn   = fs_zero ? lead_or_active : RG_FRAME_LEAD;
      base_cnt   = '0;
      base_line  = '0;
      base_phase = PH_Y0;
    end else begin
      base_rgn   = region_r;
      base_cnt   = cnt_r;
      base_line  = line_r;
      base_phase = phase_r;
    end
  end

  // length of the current region and line position
  always_comb begin
    case (base_rgn)
      RG_FRAME_LEAD: rgn_len = fs_r;
      RG_LINE_LEAD:  rgn_len = FS_W'(ls_r);
      RG_ACTIVE:     rgn_len = FS_W'({eff_w, 1'b0});
      RG_LINE_TAIL:  rgn_len = FS_W'(le_r);
      default:       rgn_len = '0;
    endcase
  end

  assign cnt_inc = base_cnt + 1'b1;
  assign rgn_end = (cnt_inc >= rgn_len);
  assign last_ln = ((CW'(base_line) + 1'b1) >= CW'(eff_h));

  // next state and job build
  always_comb begin
    region_nxt = region_r;
    cnt_nxt    = cnt_r;
    line_nxt   = line_r;
    phase_nxt  = phase_r;
    h0_nxt     = h0_r;
    h1_nxt     = h1_r;
    h2_nxt     = h2_r;
    push_valid = 1'b0;
    push_job   = '0;

    if (accept) begin
      region_nxt = base_rgn;
      cnt_nxt    = base_cnt;
      line_nxt   = base_line;
      phase_nxt  = base_phase;

      if (base_rgn inside {RG_FRAME_LEAD, RG_LINE_LEAD, RG_ACTIVE, RG_LINE_TAIL}) begin
        // byte assembly inside the active part
        if (base_rgn == RG_ACTIVE) begin
          if (mode_r == MODE_DEPTH) begin
            if (base_phase != PH_U) begin
              h0_nxt    = in_byte;
              phase_nxt = PH_U;
            end else begin
              push_valid    = 1'b1;
              push_job.kind = JOB_DEPTH;
              push_job.b0   = h0_r;
              push_job.b1   = in_byte;
              phase_nxt     = PH_Y0;
            end
          end else begin
            case (base_phase)
              PH_Y0: begin
                h0_nxt    = in_byte;
                phase_nxt = PH_U;
              end
              PH_U: begin
                h1_nxt    = in_byte;
                phase_nxt = PH_Y1;
              end
              PH_Y1: begin
                h2_nxt    = in_byte;
                phase_nxt = PH_V;
              end
              default: begin
                push_valid    = 1'b1;
                push_job.kind = JOB_RGB_TWO;
                push_job.b0   = h0_r;
                push_job.b1   = h1_r;
                push_job.b2   = h2_r;
                push_job.b3   = in_byte;
                phase_nxt     = PH_Y0;
              end
            endcase
          end
        end

        // region end and move to the next non-empty region
        if (rgn_end) begin
          cnt_nxt = '0;
          if (base_rgn == RG_ACTIVE) begin
            // line ended after y0 and u: one pixel with neutral v
            if (mode_r == MODE_YUYV && phase_nxt == PH_Y1) begin
              push_valid    = 1'b1;
              push_job.kind = JOB_RGB_ONE;
              push_job.b0   = h0_r;
              push_job.b1   = in_byte;
              push_job.b3   = CHROMA_ZERO;
            end
            push_job.eol = push_valid;
            push_job.eof = push_valid && last_ln;
            phase_nxt    = PH_Y0;
          end
          case (base_rgn)
            RG_FRAME_LEAD: begin
              region_nxt = lead_or_active;
            end
            RG_LINE_LEAD: begin
              region_nxt = RG_ACTIVE;
            end
            RG_ACTIVE: begin
              if (last_ln) begin
                region_nxt = RG_DONE;
              end else if (le_zero) begin
                region_nxt = lead_or_active;
                line_nxt   = base_line + 1'b1;
              end else begin
                region_nxt = RG_LINE_TAIL;
              end
            end
            RG_LINE_TAIL: begin
              region_nxt = lead_or_active;
              line_nxt   = base_line + 1'b1;
            end
            default: region_nxt = RG_DONE;
          endcase
          if (region_nxt == RG_ACTIVE) begin
            phase_nxt = PH_Y0;
          end
        end else begin
          cnt_nxt = cnt_inc;
        end
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      region_r <= RG_IDLE;
      cnt_r    <= '0;
      line_r   <= '0;
      phase_r  <= PH_Y0;
    end else begin
      region_r <= region_nxt;
      cnt_r    <= cnt_nxt;
      line_r   <= line_nxt;
      phase_r  <= phase_nxt;
    end
  end

  // held bytes of a partial pixel group
  always_ff @(posedge clk) begin
    h0_r <= h0_nxt;
    h1_r <= h1_nxt;
    h2_r <= h2_nxt;
  end

endmodule

@@ sv/csfu_back.sv @@
// pixel converter: bt.601 products, sums with clamp, and result serializer
module csfu_back import csfu_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        job_valid,
  output logic        job_ready,
  input  job_t        job,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic [15:0] out_depth,
  output logic        out_eol,
  output logic        out_eof,
  output logic        out_last
);

  // stage 1: products
  logic               s1_valid_r;
  job_kind_t          s1_kind_r;
  logic [15:0]        s1_depth_r;
  logic               s1_eol_r;
  logic               s1_eof_r;
  logic signed [19:0] s1_c0_r, s1_c1_r;
  logic signed [19:0] s1_e409_r, s1_e208_r, s1_d100_r, s1_d516_r;

  // stage 2: results waiting on the output
  logic               s2_valid_r;
  logic               s2_two_r;
  logic               s2_idx_r;
  logic [7:0]         s2_r0_r, s2_g0_r, s2_b0_r;
  logic [7:0]         s2_r1_r, s2_g1_r, s2_b1_r;
  logic [15:0]        s2_depth_r;
  logic               s2_eol_r;
  logic               s2_eof_r;

  logic signed [9:0]  c0, c1, dd, ee;
  logic signed [19:0] c0x, c1x, ddx, eex;
  logic signed [19:0] r0_sum, g0_sum, b0_sum, r1_sum, g1_sum, b1_sum;
  logic               s2_last;
  logic               s2_take;
  logic               s1_take;
  logic               s1_adv;
  logic               is_rgb;

  // offsets of y, u and v
  assign c0  = signed'({2'b00, job.b0}) - 10'sd16;
  assign c1  = signed'({2'b00, job.b2}) - 10'sd16;
  assign dd  = signed'({2'b00, job.b1}) - 10'sd128;
  assign ee  = signed'({2'b00, job.b3}) - 10'sd128;
  assign c0x = 20'(c0);
  assign c1x = 20'(c1);
  assign ddx = 20'(dd);
  assign eex = 20'(ee);

  // handshake between stages
  assign s2_last   = s2_two_r ? s2_idx_r : 1'b1;
  assign s2_take   = !s2_valid_r || (out_ready && s2_last);
  assign s1_adv    = s1_valid_r && s2_take;
  assign s1_take   = !s1_valid_r || s2_take;
  assign job_ready = s1_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_take) begin
      s1_valid_r <= job_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take && job_valid) begin
      s1_kind_r  <= job.kind;
      s1_depth_r <= {job.b1, job.b0};
      s1_eol_r   <= job.eol;
      s1_eof_r   <= job.eof;
      s1_c0_r    <= c0x * 20'sd298;
      s1_c1_r    <= c1x * 20'sd298;
      s1_e409_r  <= eex * 20'sd409;
      s1_e208_r  <= eex * 20'sd208;
      s1_d100_r  <= ddx * 20'sd100;
      s1_d516_r  <= ddx * 20'sd516;
    end
  end

  // channel sums with rounding
  assign r0_sum = s1_c0_r + s1_e409_r + 20'sd128;
  assign g0_sum = s1_c0_r - s1_d100_r - s1_e208_r + 20'sd128;
  assign b0_sum = s1_c0_r + s1_d516_r + 20'sd128;
  assign r1_sum = s1_c1_r + s1_e409_r + 20'sd128;
  assign g1_sum = s1_c1_r - s1_d100_r - s1_e208_r + 20'sd128;
  assign b1_sum = s1_c1_r + s1_d516_r + 20'sd128;
  assign is_rgb = (s1_kind_r != JOB_DEPTH);

  // output stage control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
      s2_idx_r   <= 1'b0;
    end else if (s2_take) begin
      s2_valid_r <= s1_valid_r;
      s2_idx_r   <= 1'b0;
    end else if (out_ready) begin
      s2_idx_r   <= 1'b1;
    end
  end

  // output stage payload
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s2_two_r   <= (s1_kind_r == JOB_RGB_TWO);
      s2_r0_r    <= is_rgb ? clamp8(r0_sum) : 8'd0;
      s2_g0_r    <= is_rgb ? clamp8(g0_sum) : 8'd0;
      s2_b0_r    <= is_rgb ? clamp8(b0_sum) : 8'd0;
      s2_r1_r    <= clamp8(r1_sum);
      s2_g1_r    <= clamp8(g1_sum);
      s2_b1_r    <= clamp8(b1_sum);
      s2_depth_r <= is_rgb ? 16'd0 : s1_depth_r;
      s2_eol_r   <= s1_eol_r;
      s2_eof_r   <= s1_eof_r;
    end
  end

  // result selection, flags only on the last result of the job
  assign out_valid = s2_valid_r;
  assign out_red   = s2_idx_r ? s2_r1_r : s2_r0_r;
  assign out_green = s2_idx_r ? s2_g1_r : s2_g0_r;
  assign out_blue  = s2_idx_r ? s2_b1_r : s2_b0_r;
  assign out_depth = s2_depth_r;
  assign out_eol   = s2_last && s2_eol_r;
  assign out_eof   = s2_last && s2_eof_r;
  assign out_last  = s2_last;

endmodule
